### src/ulq_pkg.sv
package ulq_pkg;

  localparam int unsigned DEFAULT_DEPTH = 32;
  localparam int unsigned SYM_W         = 8;

  typedef enum logic [1:0] {
    ACT_SERVE = 2'd0,
    ACT_ENTER = 2'd1,
    ACT_CUT   = 2'd2,
    ACT_LEAVE = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_EMPTY     = 3'd1,
    STAT_FULL      = 3'd2,
    STAT_PRESENT   = 3'd3,
    STAT_ABSENT    = 3'd4,
    STAT_NO_TARGET = 3'd5
  } status_e;

  // broadcast from the sequencer to every cell
  typedef struct packed {
    logic             capture;
    logic             scan;
    logic             apply;
    action_e          act;
    logic [SYM_W-1:0] symbol;
    logic [SYM_W-1:0] target;
  } cell_ctrl_t;

endpackage

### src/ulq_cell.sv
module ulq_cell #(
  parameter int unsigned DEPTH = ulq_pkg::DEFAULT_DEPTH,
  parameter int unsigned IDX   = 0
) (
  input  logic                        clk_i,
  input  ulq_pkg::cell_ctrl_t         ctrl_i,
  input  logic [$clog2(DEPTH+1)-1:0]  count_i,
  input  logic [ulq_pkg::SYM_W-1:0]   left_sym_i,
  input  logic                        left_ps_i,
  input  logic                        left_pt_i,
  input  logic [ulq_pkg::SYM_W-1:0]   right_sym_i,
  input  logic [ulq_pkg::SYM_W:0]     right_tv_i,
  output logic [ulq_pkg::SYM_W-1:0]   sym_o,
  output logic                        ps_o,
  output logic                        pt_o,
  output logic [ulq_pkg::SYM_W:0]     tv_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [ulq_pkg::SYM_W-1:0] sym_q, sym_d;
  logic                      ps_q, ps_d;
  logic                      pt_q, pt_d;
  logic [ulq_pkg::SYM_W:0]   tv_q, tv_d;
  logic [CW:0]               cnt_x;
  logic                      occ, ms, mt, is_last, is_pre_last;

  assign cnt_x       = {1'b0, count_i};
  assign occ         = cnt_x > (CW+1)'(IDX);
  assign is_last     = cnt_x == (CW+1)'(IDX + 1);
  assign is_pre_last = cnt_x == (CW+1)'(IDX + 2);
  assign ms          = occ && (sym_q == ctrl_i.symbol);
  assign mt          = occ && (sym_q == ctrl_i.target);

  // match flags run rightwards, the tail lookup runs leftwards
  always_comb begin
    ps_d = ps_q;
    pt_d = pt_q;
    tv_d = tv_q;
    if (ctrl_i.capture) begin
      ps_d = ms;
      pt_d = mt;
      tv_d = {ms && is_last, is_pre_last ? sym_q : '0};
    end else if (ctrl_i.scan) begin
      ps_d = ps_q | left_ps_i;
      pt_d = pt_q | left_pt_i;
      tv_d = tv_q | right_tv_i;
    end
  end

  always_comb begin
    sym_d = sym_q;
    if (ctrl_i.apply) begin
      unique case (ctrl_i.act)
        ulq_pkg::ACT_SERVE: sym_d = right_sym_i;
        ulq_pkg::ACT_ENTER: begin
          if (cnt_x == (CW+1)'(IDX)) sym_d = ctrl_i.symbol;
        end
        ulq_pkg::ACT_CUT: begin
          if (left_pt_i) sym_d = left_sym_i;
          else if (pt_q) sym_d = ctrl_i.symbol;
        end
        ulq_pkg::ACT_LEAVE: begin
          if (ps_q) sym_d = right_sym_i;
        end
        default: sym_d = sym_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q <= sym_d;
    ps_q  <= ps_d;
    pt_q  <= pt_d;
    tv_q  <= tv_d;
  end

  assign sym_o = sym_q;
  assign ps_o  = ps_q;
  assign pt_o  = pt_q;
  assign tv_o  = tv_q;

endmodule

### src/unique_symbol_line_queue.sv
// unique symbol line queue
//
// keeps an ordered line of up to DEPTH distinct byte symbols. each request on
// the input channel (in_valid_i / in_stall_o) carries an action, a symbol and
// a target: serve the head, enter at the back, cut in before the target, or
// leave. each request yields exactly one result on the output channel
// (out_valid_o / out_stall_i): status, served symbol, count, head and tail.
//
// the line lives in a row of DEPTH cells. a request is compared in every cell
// at once, then the match flags ripple one cell per cycle rightwards (and a
// tail lookup leftwards) across the whole row, then all cells shift at once.
// the result is registered in the shift step, and a new request is taken
// only after the shift step of the one before it.
//
// reset empties the line (count zero, tail zero); symbol storage is left as
// is. while the receiver stalls, the result holds; a new request may be taken
// meanwhile, but its shift step waits until the held result has gone.
module unique_symbol_line_queue #(
  parameter int unsigned DEPTH = ulq_pkg::DEFAULT_DEPTH
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                action_i,
  input  logic [ulq_pkg::SYM_W-1:0] symbol_i,
  input  logic [ulq_pkg::SYM_W-1:0] target_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [2:0]                status_o,
  output logic [ulq_pkg::SYM_W-1:0] served_symbol_o,
  output logic [5:0]                count_o,
  output logic [ulq_pkg::SYM_W-1:0] head_symbol_o,
  output logic [ulq_pkg::SYM_W-1:0] tail_symbol_o
);

  localparam int unsigned CW  = $clog2(DEPTH + 1);
  localparam int unsigned SCW = $clog2(DEPTH);
  localparam int unsigned SW  = ulq_pkg::SYM_W;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CAPT  = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_APPLY = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic [SCW-1:0] scan_q, scan_d;
  logic [CW-1:0]  count_q, count_d;
  logic [SW-1:0]  tail_q, tail_d;

  // latched request
  ulq_pkg::action_e act_q;
  logic [SW-1:0]    req_sym_q, req_tgt_q;

  // result register
  logic             out_valid_q, out_valid_d;
  ulq_pkg::status_e status_q, status_d;
  logic [SW-1:0]    served_q, served_d;
  logic [CW-1:0]    res_cnt_q;
  logic [SW-1:0]    head_q, head_d;
  logic [SW-1:0]    res_tail_q;

  logic [SW-1:0] cell_sym [DEPTH];
  logic          cell_ps  [DEPTH];
  logic          cell_pt  [DEPTH];
  logic [SW:0]   cell_tv  [DEPTH];

  ulq_pkg::cell_ctrl_t ctrl;

  logic in_acc, out_acc, out_free, do_apply, ok;
  logic found_sym, found_tgt, full, empty;
  logic [CW+5:0] cnt_ext;

  assign in_acc    = in_valid_i && !in_stall_o;
  assign out_acc   = out_valid_q && !out_stall_i;
  assign out_free  = !(out_valid_q && out_stall_i);
  assign do_apply  = (state_q == ST_APPLY) && out_free;
  assign found_sym = cell_ps[DEPTH-1];
  assign found_tgt = cell_pt[DEPTH-1];
  assign full      = count_q == CW'(DEPTH);
  assign empty     = count_q == '0;

  // request is taken only between operations
  assign in_stall_o = state_q != ST_IDLE;

  always_comb begin
    state_d = state_q;
    scan_d  = scan_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) state_d = ST_CAPT;
      end
      ST_CAPT: begin
        scan_d  = '0;
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        scan_d = scan_q + SCW'(1);
        if (scan_q == SCW'(DEPTH - 2)) state_d = ST_APPLY;
      end
      ST_APPLY: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // status, in the checking order of each action
  always_comb begin
    status_d = ulq_pkg::STAT_OK;
    unique case (act_q)
      ulq_pkg::ACT_SERVE: begin
        if (empty) status_d = ulq_pkg::STAT_EMPTY;
      end
      ulq_pkg::ACT_ENTER: begin
        if (full) status_d = ulq_pkg::STAT_FULL;
        else if (found_sym) status_d = ulq_pkg::STAT_PRESENT;
      end
      ulq_pkg::ACT_CUT: begin
        if (full) status_d = ulq_pkg::STAT_FULL;
        else if (found_sym) status_d = ulq_pkg::STAT_PRESENT;
        else if (!found_tgt) status_d = ulq_pkg::STAT_NO_TARGET;
      end
      ulq_pkg::ACT_LEAVE: begin
        if (!found_sym) status_d = ulq_pkg::STAT_ABSENT;
      end
      default: status_d = ulq_pkg::STAT_OK;
    endcase
  end

  assign ok = status_d == ulq_pkg::STAT_OK;

  // line view after the shift, worked out from the cells before it
  always_comb begin
    count_d  = count_q;
    tail_d   = tail_q;
    head_d   = cell_sym[0];
    served_d = '0;
    if (ok) begin
      unique case (act_q)
        ulq_pkg::ACT_SERVE: begin
          count_d  = count_q - CW'(1);
          head_d   = cell_sym[1];
          served_d = cell_sym[0];
        end
        ulq_pkg::ACT_ENTER: begin
          count_d = count_q + CW'(1);
          tail_d  = req_sym_q;
          if (empty) head_d = req_sym_q;
        end
        ulq_pkg::ACT_CUT: begin
          count_d = count_q + CW'(1);
          if (cell_pt[0]) head_d = req_sym_q;
        end
        ulq_pkg::ACT_LEAVE: begin
          count_d = count_q - CW'(1);
          if (cell_ps[0]) head_d = cell_sym[1];
          // leaving symbol was the tail: the one before it takes over
          if (cell_tv[0][SW]) tail_d = cell_tv[0][SW-1:0];
        end
        default: count_d = count_q;
      endcase
    end
    if (count_d == '0) begin
      head_d = '0;
      tail_d = '0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_acc) out_valid_d = 1'b0;
    if (do_apply) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      scan_q      <= '0;
      count_q     <= '0;
      tail_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_q      <= scan_d;
      out_valid_q <= out_valid_d;
      if (do_apply) begin
        count_q <= count_d;
        tail_q  <= tail_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      act_q     <= ulq_pkg::action_e'(action_i);
      req_sym_q <= symbol_i;
      req_tgt_q <= target_i;
    end
    if (do_apply) begin
      status_q   <= status_d;
      served_q   <= served_d;
      res_cnt_q  <= count_d;
      head_q     <= head_d;
      res_tail_q <= tail_d;
    end
  end

  assign ctrl.capture = state_q == ST_CAPT;
  assign ctrl.scan    = state_q == ST_SCAN;
  assign ctrl.apply   = do_apply && ok;
  assign ctrl.act     = act_q;
  assign ctrl.symbol  = req_sym_q;
  assign ctrl.target  = req_tgt_q;

  // the row of cells, head at index zero
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [SW-1:0] left_sym, right_sym;
    logic          left_ps, left_pt;
    logic [SW:0]   right_tv;

    if (k == 0) begin : g_head
      assign left_sym = '0;
      assign left_ps  = 1'b0;
      assign left_pt  = 1'b0;
    end else begin : g_mid
      assign left_sym = cell_sym[k-1];
      assign left_ps  = cell_ps[k-1];
      assign left_pt  = cell_pt[k-1];
    end

    if (k == DEPTH - 1) begin : g_end
      assign right_sym = '0;
      assign right_tv  = '0;
    end else begin : g_inner
      assign right_sym = cell_sym[k+1];
      assign right_tv  = cell_tv[k+1];
    end

    ulq_cell #(
      .DEPTH (DEPTH),
      .IDX   (k)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .count_i     (count_q),
      .left_sym_i  (left_sym),
      .left_ps_i   (left_ps),
      .left_pt_i   (left_pt),
      .right_sym_i (right_sym),
      .right_tv_i  (right_tv),
      .sym_o       (cell_sym[k]),
      .ps_o        (cell_ps[k]),
      .pt_o        (cell_pt[k]),
      .tv_o        (cell_tv[k])
    );
  end

  assign cnt_ext         = {6'd0, res_cnt_q};
  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign served_symbol_o = served_q;
  assign count_o         = cnt_ext[5:0];
  assign head_symbol_o   = head_q;
  assign tail_symbol_o   = res_tail_q;

  // a taken request always starts the compare step
  a_accept_capt : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == ST_CAPT)
    else $error("request taken but compare step did not follow");

  // the count never exceeds the line length
  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("count beyond line length");

  // the count moves only in the shift step
  a_count_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !do_apply |=> $stable(count_q))
    else $error("count changed outside shift step");

  // every shift step posts a result
  a_apply_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_apply |=> out_valid_q)
    else $error("shift step without result");

  // a serve on a non-empty line drops the count by one
  a_serve_dec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_apply && act_q == ulq_pkg::ACT_SERVE && !empty)
      |=> count_q == $past(count_q) - CW'(1))
    else $error("serve did not remove one symbol");

endmodule

### tb/tb_unique_symbol_line_queue.sv
`timescale 1ns / 1ps

// testbench for the unique symbol line queue
//
// a request stream of serve, enter, cut and leave operations is driven into
// the block while a queue-based predictor keeps its own copy of the line. each
// accepted request pushes one predicted result; each accepted result is
// checked field by field against the oldest prediction
module tb_unique_symbol_line_queue;

  localparam int unsigned DEPTH = ulq_pkg::DEFAULT_DEPTH;
  localparam int unsigned SYM_W = ulq_pkg::SYM_W;
  // a request's pass through the block, a long receiver stall or a sender gap
  // still sits far below this
  localparam int unsigned QUIET_LIMIT = 2000;

  // one predicted result, laid out like the output ports
  typedef struct packed {
    ulq_pkg::status_e    status;
    logic [SYM_W-1:0]    served;
    logic [5:0]          count;
    logic [SYM_W-1:0]    head;
    logic [SYM_W-1:0]    tail;
  } line_result_t;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_stall_o;
  logic [1:0]       action_i    = 2'd0;
  logic [SYM_W-1:0] symbol_i    = '0;
  logic [SYM_W-1:0] target_i    = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [2:0]       status_o;
  logic [SYM_W-1:0] served_symbol_o;
  logic [5:0]       count_o;
  logic [SYM_W-1:0] head_symbol_o;
  logic [SYM_W-1:0] tail_symbol_o;

  // predictor state: the line as the block should hold it, head first
  logic [SYM_W-1:0] line_q[$];
  // results predicted but not yet seen at the output
  line_result_t     pending_results_q[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;

  unique_symbol_line_queue #(
    .DEPTH (DEPTH)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .action_i        (action_i),
    .symbol_i        (symbol_i),
    .target_i        (target_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .served_symbol_o (served_symbol_o),
    .count_o         (count_o),
    .head_symbol_o   (head_symbol_o),
    .tail_symbol_o   (tail_symbol_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // line predictor
  // ---------------------------------------------------------------------------

  // position of a symbol in the line, -1 when it is not in line
  function automatic int find_symbol(logic [SYM_W-1:0] sym);
    foreach (line_q[i]) begin
      if (line_q[i] == sym) return i;
    end
    return -1;
  endfunction

  // apply one accepted request to the line and queue the result it gives
  function automatic void apply_request(ulq_pkg::action_e act, logic [SYM_W-1:0] sym,
                                        logic [SYM_W-1:0] tgt);
    line_result_t res;
    int           pos;
    res        = '0;
    res.status = ulq_pkg::STAT_OK;
    case (act)
      ulq_pkg::ACT_SERVE: begin
        if (line_q.size() == 0) res.status = ulq_pkg::STAT_EMPTY;
        else res.served = line_q.pop_front();
      end
      ulq_pkg::ACT_ENTER: begin
        // a full line wins over a duplicate symbol
        if (line_q.size() >= DEPTH) res.status = ulq_pkg::STAT_FULL;
        else if (find_symbol(sym) >= 0) res.status = ulq_pkg::STAT_PRESENT;
        else line_q.push_back(sym);
      end
      ulq_pkg::ACT_CUT: begin
        // full, then duplicate symbol, then missing target
        if (line_q.size() >= DEPTH) res.status = ulq_pkg::STAT_FULL;
        else if (find_symbol(sym) >= 0) res.status = ulq_pkg::STAT_PRESENT;
        else begin
          pos = find_symbol(tgt);
          if (pos < 0) res.status = ulq_pkg::STAT_NO_TARGET;
          else line_q.insert(pos, sym);
        end
      end
      default: begin
        pos = find_symbol(sym);
        if (pos < 0) res.status = ulq_pkg::STAT_ABSENT;
        else line_q.delete(pos);
      end
    endcase
    res.count = 6'(line_q.size());
    if (line_q.size() != 0) begin
      res.head = line_q[0];
      res.tail = line_q[line_q.size() - 1];
    end
    pending_results_q.push_back(res);
  endfunction

  // a symbol already in line, or any symbol when the line is empty
  function automatic logic [SYM_W-1:0] pick_present();
    if (line_q.size() == 0) return SYM_W'($urandom_range(255));
    return line_q[$urandom_range(line_q.size() - 1)];
  endfunction

  // a symbol not in line; the line never holds more than DEPTH of 256
  function automatic logic [SYM_W-1:0] pick_absent();
    logic [SYM_W-1:0] sym;
    do sym = SYM_W'($urandom_range(255)); while (find_symbol(sym) >= 0);
    return sym;
  endfunction

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------

  // called at a rising edge; returns at the rising edge that takes the request.
  // valid stays high into the next request unless a gap is drawn, so valid
  // only ever gets one assignment per edge
  task automatic send_request(ulq_pkg::action_e act, logic [SYM_W-1:0] sym,
                              logic [SYM_W-1:0] tgt);
    int unsigned gap;
    bit          taken;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    symbol_i   <= sym;
    target_i   <= tgt;
    // stall is settled by the falling edge, so the decision is free of races
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    apply_request(act, sym, tgt);
  endtask

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  function automatic void check_field(string name, logic [SYM_W-1:0] want,
                                      logic [SYM_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // outputs and stall are stable at the falling edge; a result seen valid and
  // unstalled here is taken at the next rising edge
  always @(negedge clk_i) begin : result_check
    line_result_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      if (pending_results_q.size() == 0) begin
        $error("result with no request outstanding: status %0d", status_o);
        mismatch_count++;
      end else begin
        want = pending_results_q.pop_front();
        check_field("status", SYM_W'(want.status), SYM_W'(status_o));
        check_field("served_symbol", want.served, served_symbol_o);
        check_field("count", SYM_W'(want.count), SYM_W'(count_o));
        check_field("head_symbol", want.head, head_symbol_o);
        check_field("tail_symbol", want.tail, tail_symbol_o);
      end
    end
  end

  // watchdog on cycles in which neither channel moves anything
  always @(negedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // operations on an empty line, then the first entries at the symbol extremes
  task automatic test_empty_line();
    send_request(ulq_pkg::ACT_SERVE, 8'd0,   8'd0);    // serve when empty
    send_request(ulq_pkg::ACT_LEAVE, 8'd0,   8'd0);    // leave when empty
    send_request(ulq_pkg::ACT_CUT,   8'd255, 8'd255);  // symbol equals target, both absent
    send_request(ulq_pkg::ACT_ENTER, 8'd0,   8'd0);
    send_request(ulq_pkg::ACT_ENTER, 8'd255, 8'd0);
  endtask

  // every outcome of enter, cut and leave on a short line but the full status
  task automatic test_line_edits();
    send_request(ulq_pkg::ACT_ENTER, 8'd0,   8'd0);    // already present
    send_request(ulq_pkg::ACT_CUT,   8'd128, 8'd255);  // cut in before the tail
    send_request(ulq_pkg::ACT_CUT,   8'd1,   8'd0);    // cut in before the head
    send_request(ulq_pkg::ACT_CUT,   8'd0,   8'd255);  // cut of a symbol already in line
    send_request(ulq_pkg::ACT_CUT,   8'd7,   8'd99);   // target absent
    send_request(ulq_pkg::ACT_CUT,   8'd1,   8'd1);    // symbol equals target, present
    send_request(ulq_pkg::ACT_CUT,   8'd42,  8'd42);   // symbol equals target, absent
    send_request(ulq_pkg::ACT_LEAVE, 8'd99,  8'd0);    // not present
    send_request(ulq_pkg::ACT_LEAVE, 8'd128, 8'd0);    // from the middle
    send_request(ulq_pkg::ACT_LEAVE, 8'd255, 8'd0);    // the tail
    send_request(ulq_pkg::ACT_SERVE, 8'd0,   8'd0);
    send_request(ulq_pkg::ACT_ENTER, 8'd170, 8'd85);
    send_request(ulq_pkg::ACT_ENTER, 8'd85,  8'd170);
    send_request(ulq_pkg::ACT_LEAVE, 8'd0,   8'd0);    // the head
    send_request(ulq_pkg::ACT_SERVE, 8'd0,   8'd0);
    send_request(ulq_pkg::ACT_SERVE, 8'd0,   8'd0);
    send_request(ulq_pkg::ACT_SERVE, 8'd0,   8'd0);    // empty again
  endtask

  // fill to DEPTH, check that full wins over every other status, then drain
  task automatic test_full_line();
    while (line_q.size() < DEPTH) send_request(ulq_pkg::ACT_ENTER, pick_absent(), 8'd0);
    send_request(ulq_pkg::ACT_ENTER, pick_absent(),  8'd0);
    send_request(ulq_pkg::ACT_ENTER, pick_present(), 8'd0);
    send_request(ulq_pkg::ACT_CUT,   pick_absent(),  pick_present());
    send_request(ulq_pkg::ACT_CUT,   pick_present(), pick_absent());
    send_request(ulq_pkg::ACT_LEAVE, pick_absent(),  8'd0);
    send_request(ulq_pkg::ACT_SERVE, 8'd0,           8'd0);
    // back to full by a cut
    send_request(ulq_pkg::ACT_CUT,   pick_absent(),  line_q[line_q.size() - 1]);
    while (line_q.size() != 0) begin
      if ($urandom_range(1)) send_request(ulq_pkg::ACT_SERVE, 8'd0, 8'd0);
      else send_request(ulq_pkg::ACT_LEAVE, pick_present(), 8'd0);
    end
  endtask

  // mostly well-formed requests steered toward a fill level that moves around,
  // with some random noise and deliberately broken requests mixed in
  task automatic test_random_requests(int unsigned n_items);
    int unsigned      goal;
    int unsigned      roll;
    int unsigned      i;
    ulq_pkg::action_e act;
    logic [SYM_W-1:0] sym;
    logic [SYM_W-1:0] tgt;
    goal = 0;
    for (i = 0; i < n_items; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(3))
          0:       goal = 0;
          1:       goal = DEPTH;
          default: goal = $urandom_range(DEPTH);
        endcase
      end
      sym  = pick_absent();
      tgt  = pick_present();
      roll = $urandom_range(99);
      if (roll < 12) begin
        act = ulq_pkg::action_e'($urandom_range(3));
        sym = SYM_W'($urandom_range(255));
        tgt = SYM_W'($urandom_range(255));
      end else if (roll < 20) begin
        // broken: duplicate symbol, missing target or absent leaver
        act = ulq_pkg::action_e'($urandom_range(3));
        if (act == ulq_pkg::ACT_LEAVE) sym = pick_absent();
        else if (act == ulq_pkg::ACT_CUT && $urandom_range(1)) tgt = pick_absent();
        else sym = pick_present();
      end else begin
        roll = $urandom_range(99);
        if (line_q.size() < goal) begin
          act = (roll < 45) ? ulq_pkg::ACT_ENTER : (roll < 80) ? ulq_pkg::ACT_CUT :
                (roll < 90) ? ulq_pkg::ACT_SERVE : ulq_pkg::ACT_LEAVE;
        end else begin
          act = (roll < 35) ? ulq_pkg::ACT_SERVE : (roll < 70) ? ulq_pkg::ACT_LEAVE :
                (roll < 85) ? ulq_pkg::ACT_ENTER : ulq_pkg::ACT_CUT;
        end
        if (act == ulq_pkg::ACT_LEAVE) sym = pick_present();
      end
      send_request(act, sym, tgt);
    end
  endtask

  initial begin
    send_idle_pct = 37;
    recv_idle_pct = 72;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_line();
    test_line_edits();
    test_full_line();
    test_random_requests(550);

    send_idle_pct = 72;
    recv_idle_pct = 37;
    test_random_requests(550);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_requests(550);

    in_valid_i <= 1'b0;
    // the watchdog bounds this wait if a result never shows up
    while (pending_results_q.size() != 0) @(posedge clk_i);
    // catch any stray result after the last one
    repeat (2 * DEPTH + 8) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
